/* sv/mep_pkg.sv */
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
package mep_pkg;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [63:0] product_type;

   localparam int DEFAULT_IMAGE_SIZE    = 256;
   localparam int DEFAULT_FRACTION_BITS = 27;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COUNT_WIDTH     = 16;
   localparam int SHADE_WIDTH     = 4;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RE_MIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RE_MAX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IM_MIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IM_MAX = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIMIT  = 3'd4;

   // Reset window is -2.0 .. 0.5 by -1.25 .. 1.25 in Q5.27.
   localparam coord_type RE_MIN_RESET = 32'shF000_0000;
   localparam coord_type RE_MAX_RESET = 32'sh0400_0000;
   localparam coord_type IM_MIN_RESET = 32'shF600_0000;
   localparam coord_type IM_MAX_RESET = 32'sh0A00_0000;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 16'd1000;

   localparam logic [SHADE_WIDTH-1:0] SHADE_AT_LIMIT = 4'd9;
   localparam logic [SHADE_WIDTH-1:0] SHADE_WRAP     = 4'd8;

   // Clamp a wide signed value into the 32-bit coordinate range.
   function automatic coord_type sat32(input logic signed [64:0] x);
      coord_type result;
      if (x > 65'sd2147483647) begin
         result = 32'sh7FFF_FFFF;
      end else if (x < -65'sd2147483648) begin
         result = 32'sh8000_0000;
      end else begin
         result = x[31:0];
      end
      return result;
   endfunction

endpackage

/* sv/mep_mul.sv */
// Shared 32 by 32 signed multiplier with a registered product.
module mep_mul (
   input  logic                 clock,
   input  mep_pkg::coord_type   mul_a,
   input  mep_pkg::coord_type   mul_b,
   output mep_pkg::product_type product
);
   import mep_pkg::*;

   product_type product_ff;
   product_type product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* sv/mandelbrot_escape_pixel.sv */
// Top level of the Mandelbrot escape-time pixel block: sequencer, datapath and ports.
// After the input transfer the sequencer forms the steps (S_STEP), maps the pixel to c
// (S_MRE, S_MIM, S_CIM), iterates until the iteration limit or an escape stops it, and
// then registers the result (S_DONE). One pixel at a time; each iteration passes S_RR, S_II,
// S_RI and, unless z escapes, S_UPD, as one shared multiplier forms zr*zr, zi*zi and zr*zi in turn.
// Reset is synchronous and active high: the window and limit return to their
// defaults, the sequencer goes idle and no result is pending.
module mandelbrot_escape_pixel #(
   parameter int IMAGE_SIZE    = mep_pkg::DEFAULT_IMAGE_SIZE,
   parameter int FRACTION_BITS = mep_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [7:0] pixel_row, [15:8] pixel_column
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,  // [15:0] escape_count, [19:16] shade_digit, [23:20] zero
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mep_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data
);
   import mep_pkg::*;

   // The span is divided by the image size as a shift of floor(log2(IMAGE_SIZE)).
   localparam int SIZE_SHIFT = $clog2(IMAGE_SIZE + 1) - 1;
   // A 32-bit z cannot reach a squared magnitude above 4.0 once the fraction
   // grows past 30 bits, so escape is then impossible.
   localparam bit CAN_ESCAPE = (FRACTION_BITS <= 30);
   localparam logic [64:0] ESC_THRESH =
      CAN_ESCAPE ? (65'd1 << (2 * FRACTION_BITS + 2)) : 65'd0;

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_STEP = 4'd1;
   localparam logic [3:0] S_MRE  = 4'd2;
   localparam logic [3:0] S_MIM  = 4'd3;
   localparam logic [3:0] S_CIM  = 4'd4;
   localparam logic [3:0] S_RR   = 4'd5;
   localparam logic [3:0] S_II   = 4'd6;
   localparam logic [3:0] S_RI   = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   // Configuration registers.
   coord_type               re_min_ff, re_max_ff, im_min_ff, im_max_ff;
   logic [COUNT_WIDTH-1:0]  limit_ff;

   // Sequencer and datapath registers.
   logic [3:0]              state_ff, state_in;
   logic [7:0]              row_ff, row_in;
   logic [7:0]              col_ff, col_in;
   coord_type               step_re_ff, step_re_in;
   coord_type               step_im_ff, step_im_in;
   coord_type               c_re_ff, c_re_in;
   coord_type               c_im_ff, c_im_in;
   coord_type               zr_ff, zr_in;
   coord_type               zi_ff, zi_in;
   product_type             rr_ff, rr_in;
   product_type             diff_ff, diff_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [SHADE_WIDTH-1:0]  mod9_ff, mod9_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;
   logic [SHADE_WIDTH-1:0]  rsp_shade_ff, rsp_shade_in;

   // Shared multiplier.
   coord_type               mul_a, mul_b;
   product_type             product;

   // Datapath helpers.
   logic signed [32:0]      span_re, span_im;
   logic signed [32:0]      span_re_shifted, span_im_shifted;
   coord_type               map_base;
   logic signed [64:0]      map_sum;
   logic [64:0]             mag_sum;
   logic                    escape;
   logic signed [64:0]      new_r_wide, new_i_wide;
   logic                    slot_free;

   mep_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // Config writes are always taken; the user must have them arrive only while the block is idle, unenforced.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         re_min_ff <= RE_MIN_RESET;
         re_max_ff <= RE_MAX_RESET;
         im_min_ff <= IM_MIN_RESET;
         im_max_ff <= IM_MAX_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RE_MIN: re_min_ff <= csr_data;
            REG_RE_MAX: re_max_ff <= csr_data;
            REG_IM_MIN: im_min_ff <= csr_data;
            REG_IM_MAX: im_max_ff <= csr_data;
            REG_LIMIT:  limit_ff  <= csr_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Step per pixel: the window span shifted right, which rounds toward minus
   // infinity. A shift of at least one keeps it within 32 bits.
   assign span_re         = 33'(re_max_ff) - 33'(re_min_ff);
   assign span_im         = 33'(im_max_ff) - 33'(im_min_ff);
   assign span_re_shifted = span_re >>> SIZE_SHIFT;
   assign span_im_shifted = span_im >>> SIZE_SHIFT;

   // Coordinate = window minimum + step * index, saturated.
   assign map_base = (state_ff == S_MIM) ? re_min_ff : im_min_ff;
   assign map_sum  = 65'(map_base) + 65'(product);

   // Squared magnitude; both squares are nonnegative.
   assign mag_sum = {1'b0, rr_ff} + {1'b0, product};
   assign escape  = CAN_ESCAPE && (mag_sum > ESC_THRESH);

   // Next z: real part from the registered difference of squares, imaginary
   // part from the cross product, which the shift by one less fraction bit doubles.
   assign new_r_wide = 65'(diff_ff >>> FRACTION_BITS) + 65'(c_re_ff);
   assign new_i_wide = 65'(product >>> (FRACTION_BITS - 1)) + 65'(c_im_ff);

   // The output register can take a new result when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Multiplier operand selection per state.
   always_comb begin
      mul_a = zr_ff;
      mul_b = zr_ff;
      case (state_ff)
         S_MRE: begin
            mul_a = step_re_ff;
            mul_b = {24'd0, col_ff};
         end
         S_MIM: begin
            mul_a = step_im_ff;
            mul_b = {24'd0, row_ff};
         end
         S_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         S_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         S_RI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: ;
      endcase
   end

   // Sequencer. One pixel at a time: map, then S_RR, S_II, S_RI and, unless escaped, S_UPD per iteration.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      step_re_in   = step_re_ff;
      step_im_in   = step_im_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;
      mod9_in      = mod9_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_shade_in = rsp_shade_ff;

      // The consumer draining the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               row_in   = req_tdata[7:0];
               col_in   = req_tdata[15:8];
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            step_re_in = span_re_shifted[31:0];
            step_im_in = span_im_shifted[31:0];
            zr_in      = '0;
            zi_in      = '0;
            count_in   = '0;
            mod9_in    = '0;
            state_in   = S_MRE;
         end
         S_MRE: begin
            state_in = S_MIM;
         end
         S_MIM: begin
            c_re_in  = sat32(map_sum);
            state_in = S_CIM;
         end
         S_CIM: begin
            c_im_in  = sat32(map_sum);
            state_in = S_RR;
         end
         S_RR: begin
            // The limit check comes before any escape test of this iteration.
            if (count_ff >= limit_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_II;
            end
         end
         S_II: begin
            rr_in    = product;
            state_in = S_RI;
         end
         S_RI: begin
            diff_in = rr_ff - product;
            if (escape) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            zr_in    = sat32(new_r_wide);
            zi_in    = sat32(new_i_wide);
            count_in = count_ff + 1'b1;
            mod9_in  = (mod9_ff == SHADE_WRAP) ? '0 : mod9_ff + 1'b1;
            state_in = S_RR;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_shade_in = (count_ff >= limit_ff) ? SHADE_AT_LIMIT : mod9_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      step_re_ff   <= step_re_in;
      step_im_ff   <= step_im_in;
      c_re_ff      <= c_re_in;
      c_im_ff      <= c_im_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      rr_ff        <= rr_in;
      diff_ff      <= diff_in;
      count_ff     <= count_in;
      mod9_ff      <= mod9_in;
      rsp_count_ff <= rsp_count_in;
      rsp_shade_ff <= rsp_shade_in;
   end

   // A new pixel is taken only while idle; a waiting result does not block it.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_shade_ff, rsp_count_ff};

endmodule

/* sv/mep_checker.sv */
// Port-level checks for the Mandelbrot escape-time pixel block, bound to its top level.
module mep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // After reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // The block is busy with a pixel after its transfer and does not accept a second one back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted again right after a transfer");

   // The shade digit never leaves the range zero to nine.
   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:16] <= 4'd9))
      else $error("shade digit out of range");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
